[rtl/wsd_pkg.sv]
package wsd_pkg;

    // Built maximum of servers and the register value after reset.
    localparam int MAX_SERVERS_DEF = 16;
    localparam int NUM_SERVERS_RST = 16;

    // Field widths of the transactions.
    localparam int CFG_W = 5;
    localparam int IDX_W = 16;
    localparam int ARR_W = 31;
    localparam int SVC_W = 16;
    localparam int ID_W  = 4;
    localparam int CNT_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Jobs that may wait between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

[rtl/wraparound_server_dispatcher.sv]
// Wraparound server dispatcher. Each input transaction is a job with an index,
// an arrival tick and a service time; jobs must arrive in nondecreasing time.
// The job goes to the first free server at or after (job_index mod server
// count), wrapping to server 0, where a server released at the arrival tick
// counts as free; if none is free the job is dropped. Every input transaction
// yields exactly one output transaction with the outcome, the server, that
// server's saturating job count and the saturating running total. The server
// count is written through the configuration channel (0 acts as 1, values
// above MAX_SERVERS act as MAX_SERVERS) and may only change while the block
// is idle. The front end takes one job at a time: it takes the job, runs a
// bit-serial modulo (one index bit per cycle) and hands the start server to
// the queue, stalling its input until the push is done. The back end takes
// the job from the queue, compares, picks with count read and updates; it
// runs in parallel with the front end. No clearing pass is needed after reset.
module wraparound_server_dispatcher
    import wsd_pkg::*;
#(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration channel: server count.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // Job channel.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [IDX_W-1:0]  i_job_index,
    input  logic [ARR_W-1:0]  i_arrival_time,
    input  logic [SVC_W-1:0]  i_service_time,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_accepted,
    output logic [ID_W-1:0]   o_server_id,
    output logic [CNT_W-1:0]  o_server_job_count,
    output logic [CNT_W-1:0]  o_total_accepted
);

    // Width that holds the server count itself, and width of a server number.
    localparam int NW  = $clog2(MAX_SERVERS + 1);
    localparam int SW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int QDW = SW + ARR_W + SVC_W;

    logic [CFG_W-1:0] r_num_servers;
    logic [NW-1:0]    n_eff;
    logic             q_push;
    logic [QDW-1:0]   q_push_data;
    logic             q_pop;
    logic [QDW-1:0]   q_pop_data;
    t_q_stat          q_stat;

    // The register accepts a write in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_servers <= CFG_W'(NUM_SERVERS_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_num_servers <= i_cfg_data;
        end
    end

    // Clamp the programmed count into the range the hardware supports.
    always_comb begin
        if (r_num_servers == '0) begin
            n_eff = NW'(1);
        end else if (int'(r_num_servers) > MAX_SERVERS) begin
            n_eff = NW'(MAX_SERVERS);
        end else begin
            n_eff = NW'(r_num_servers);
        end
    end

    // Front end: takes the job transaction and works out the start server.
    wsd_front #(
        .NW (NW),
        .SW (SW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_job_index    (i_job_index),
        .i_arrival_time (i_arrival_time),
        .i_service_time (i_service_time),
        .i_n            (n_eff),
        .i_q_stat       (q_stat),
        .o_push         (q_push),
        .o_push_data    (q_push_data)
    );

    // Short queue so the front can start the next modulo while the back works.
    wsd_queue #(
        .DW (QDW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_stat      (q_stat)
    );

    // Back end: free check, wrapping pick, counters and the output register.
    wsd_back #(
        .MAX_SERVERS (MAX_SERVERS),
        .NW          (NW),
        .SW          (SW)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_n                (n_eff),
        .i_q_stat           (q_stat),
        .i_pop_data         (q_pop_data),
        .o_pop              (q_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_accepted         (o_accepted),
        .o_server_id        (o_server_id),
        .o_server_job_count (o_server_job_count),
        .o_total_accepted   (o_total_accepted)
    );

endmodule

[rtl/wsd_front.sv]
module wsd_front
    import wsd_pkg::*;
#(
    parameter int NW = 5,
    parameter int SW = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [IDX_W-1:0]        i_job_index,
    input  logic [ARR_W-1:0]        i_arrival_time,
    input  logic [SVC_W-1:0]        i_service_time,
    input  logic [NW-1:0]           i_n,
    input  t_q_stat                 i_q_stat,
    output logic                    o_push,
    output logic [SW+ARR_W+SVC_W-1:0] o_push_data
);

    localparam int STEP_W = $clog2(IDX_W);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate             r_state;
    logic [IDX_W-1:0]    r_idx;
    logic [NW-1:0]       r_rem;
    logic [NW-1:0]       r_n;
    logic [STEP_W-1:0]   r_step;
    logic [ARR_W-1:0]    r_arrive;
    logic [SVC_W-1:0]    r_service;
    logic [NW:0]         n_trial;
    logic [NW-1:0]       n_rem;
    logic                accept;

    assign accept     = i_in_valid && (r_state == F_IDLE);
    assign o_in_stall = (r_state != F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_q_stat.full;
    assign o_push_data = {r_rem[SW-1:0], r_arrive, r_service};

    // One restoring step of the remainder: bring in the next index bit.
    always_comb begin
        n_trial = {r_rem, r_idx[IDX_W-1]};
        if (n_trial >= {1'b0, r_n}) begin
            n_rem = NW'(n_trial - {1'b0, r_n});
        end else begin
            n_rem = NW'(n_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_state <= F_DIV;
                        r_step  <= '0;
                    end
                end
                F_DIV: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(IDX_W - 1)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_q_stat.full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx     <= i_job_index;
            r_rem     <= '0;
            r_n       <= i_n;
            r_arrive  <= i_arrival_time;
            r_service <= i_service_time;
        end else if (r_state == F_DIV) begin
            r_idx <= {r_idx[IDX_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    a_rem_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_PUSH) |-> (r_rem < r_n))
        else $error("start server not below the server count");

endmodule

[rtl/wsd_queue.sv]
module wsd_queue
    import wsd_pkg::*;
#(
    parameter int DW = 51
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_push_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_pop_data,
    output t_q_stat       o_stat
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [DW-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_pop_data   = r_mem[r_rp];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue read while empty");

endmodule

[rtl/wsd_back.sv]
module wsd_back
    import wsd_pkg::*;
#(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF,
    parameter int NW = 5,
    parameter int SW = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [NW-1:0]             i_n,
    input  t_q_stat                   i_q_stat,
    input  logic [SW+ARR_W+SVC_W-1:0] i_pop_data,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_accepted,
    output logic [ID_W-1:0]           o_server_id,
    output logic [CNT_W-1:0]          o_server_job_count,
    output logic [CNT_W-1:0]          o_total_accepted
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_CMP  = 4'b0010,
        B_PICK = 4'b0100,
        B_UPD  = 4'b1000
    } t_bstate;

    t_bstate                r_state;
    logic [SW-1:0]          r_start;
    logic [ARR_W-1:0]       r_arrive;
    logic [SVC_W-1:0]       r_service;
    logic [CNT_W-1:0]       r_busy [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] r_free;
    logic [SW-1:0]          r_pick;
    logic                   r_found;
    logic [CNT_W-1:0]       r_jobs [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] r_jvld;
    logic [CNT_W-1:0]       r_rd_data;
    logic                   r_rd_vld;
    logic [CNT_W-1:0]       r_total;
    logic                   r_o_valid;
    logic                   r_o_acc;
    logic [ID_W-1:0]        r_o_id;
    logic [CNT_W-1:0]       r_o_cnt;
    logic [CNT_W-1:0]       r_o_total;

    logic [MAX_SERVERS-1:0] n_free;
    logic [MAX_SERVERS-1:0] hi_free;
    logic [SW-1:0]          hi_idx;
    logic [SW-1:0]          lo_idx;
    logic [SW-1:0]          pick_c;
    logic                   upd_go;
    logic [CNT_W-1:0]       cnt_inc;

    assign o_pop  = (r_state == B_IDLE) && !i_q_stat.empty;
    assign upd_go = (r_state == B_UPD) && (!r_o_valid || !i_out_stall);
    assign cnt_inc = sat_inc(r_rd_vld ? r_rd_data : '0);

    assign o_out_valid        = r_o_valid;
    assign o_accepted         = r_o_acc;
    assign o_server_id        = r_o_id;
    assign o_server_job_count = r_o_cnt;
    assign o_total_accepted   = r_o_total;

    // A server is free when it was released at or before the arrival.
    always_comb begin
        for (int s = 0; s < MAX_SERVERS; s++) begin
            n_free[s] = (r_busy[s] <= {1'b0, r_arrive}) && (s < int'(i_n));
        end
    end

    // Wrapping pick: lowest free server at or after the start, else lowest overall.
    always_comb begin
        hi_idx = '0;
        lo_idx = '0;
        for (int s = 0; s < MAX_SERVERS; s++) begin
            hi_free[s] = r_free[s] && (s >= int'(r_start));
        end
        for (int s = MAX_SERVERS - 1; s >= 0; s--) begin
            if (hi_free[s]) begin
                hi_idx = SW'(s);
            end
            if (r_free[s]) begin
                lo_idx = SW'(s);
            end
        end
        pick_c = (|hi_free) ? hi_idx : lo_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_jvld    <= '0;
            r_total   <= '0;
            r_o_valid <= 1'b0;
            for (int s = 0; s < MAX_SERVERS; s++) begin
                r_busy[s] <= '0;
            end
        end else begin
            if (upd_go) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_state <= B_CMP;
                    end
                end
                B_CMP: begin
                    r_state <= B_PICK;
                end
                B_PICK: begin
                    r_state <= B_UPD;
                end
                B_UPD: begin
                    if (upd_go) begin
                        r_state <= B_IDLE;
                        if (r_found) begin
                            r_jvld[r_pick] <= 1'b1;
                            r_busy[r_pick] <= CNT_W'(r_arrive) + CNT_W'(r_service);
                            r_total        <= sat_inc(r_total);
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_start, r_arrive, r_service} <= i_pop_data;
        end
        if (r_state == B_CMP) begin
            r_free <= n_free;
        end
        if (r_state == B_PICK) begin
            r_pick    <= pick_c;
            r_found   <= |r_free;
            r_rd_data <= r_jobs[pick_c];
            r_rd_vld  <= r_jvld[pick_c];
        end
        if (upd_go) begin
            if (r_found) begin
                r_jobs[r_pick] <= cnt_inc;
                r_o_acc        <= 1'b1;
                r_o_id         <= ID_W'(r_pick);
                r_o_cnt        <= cnt_inc;
                r_o_total      <= sat_inc(r_total);
            end else begin
                r_o_acc   <= 1'b0;
                r_o_id    <= '0;
                r_o_cnt   <= '0;
                r_o_total <= r_total;
            end
        end
    end

    a_pick_was_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_UPD && r_found) |-> r_free[r_pick])
        else $error("job given to a server that was not free");

    a_drop_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_UPD && !r_found) |-> (r_free == '0))
        else $error("job dropped while a server was free");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("running total went down");

    a_out_follows_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> r_o_valid)
        else $error("finished job produced no result");

endmodule

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    // Run length guards. The cycle limit leaves a wide margin even with both
    // sides idling heavily.
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int LONG_HOLD       = 400;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int DIR_ROWS        = 21;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic             accepted;
        logic [ID_W-1:0]  server;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] total;
    } t_outcome;

    // A directed row either offers a job (with or without a typed-in outcome)
    // or rewrites the server count.
    typedef enum logic [1:0] {
        ROW_JOB,
        ROW_CHECKED,
        ROW_SERVERS
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [CFG_W-1:0] servers;
        logic [IDX_W-1:0] idx;
        logic [ARR_W-1:0] arr;
        logic [SVC_W-1:0] svc;
        t_outcome         want;
    } t_row;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_valid    = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data     = '0;
    logic             i_in_valid     = 1'b0;
    logic             o_in_stall;
    logic [IDX_W-1:0] i_job_index    = '0;
    logic [ARR_W-1:0] i_arrival_time = '0;
    logic [SVC_W-1:0] i_service_time = '0;
    logic             o_out_valid;
    logic             i_out_stall    = 1'b0;
    logic             o_accepted;
    logic [ID_W-1:0]  o_server_id;
    logic [CNT_W-1:0] o_server_job_count;
    logic [CNT_W-1:0] o_total_accepted;

    // Predicted state of the dispatcher: when each server frees up, how many
    // jobs each server took, the running total and the server count register.
    logic [CNT_W-1:0] busy_until_tick [MAX_SERVERS_DEF];
    logic [CNT_W-1:0] jobs_on_server  [MAX_SERVERS_DEF];
    logic [CNT_W-1:0] jobs_accepted;
    logic [CFG_W-1:0] servers_reg;

    // Outcomes of jobs taken by the block whose result transaction has not arrived yet.
    t_outcome pending_outcomes [$];

    int mismatches     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    t_row dir_rows [DIR_ROWS];

    wraparound_server_dispatcher #(
        .MAX_SERVERS (MAX_SERVERS_DEF)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_job_index        (i_job_index),
        .i_arrival_time     (i_arrival_time),
        .i_service_time     (i_service_time),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_accepted         (o_accepted),
        .o_server_id        (o_server_id),
        .o_server_job_count (o_server_job_count),
        .o_total_accepted   (o_total_accepted)
    );

    always #1 i_clk = ~i_clk;

    // A count of zero still means one server, and anything above the built
    // maximum is clipped to it.
    function automatic int active_servers();
        if (servers_reg == '0) begin
            return 1;
        end
        if (servers_reg > MAX_SERVERS_DEF) begin
            return MAX_SERVERS_DEF;
        end
        return int'(servers_reg);
    endfunction

    // Dispatch one job against the predicted state and return its outcome.
    // The search starts at index mod count and wraps; a server whose busy
    // time equals the arrival tick is already free.
    function automatic t_outcome dispatch_job(input logic [IDX_W-1:0] idx,
                                              input logic [ARR_W-1:0] arr,
                                              input logic [SVC_W-1:0] svc);
        int       n;
        int       first;
        int       s;
        t_outcome res;
        n         = active_servers();
        first     = int'(idx) % n;
        res       = '0;
        res.total = jobs_accepted;
        for (int k = 0; k < n; k++) begin
            s = (first + k) % n;
            if (busy_until_tick[s] <= {1'b0, arr}) begin
                busy_until_tick[s] = {1'b0, arr} + CNT_W'(svc);
                if (jobs_on_server[s] != CNT_MAX) begin
                    jobs_on_server[s]++;
                end
                if (jobs_accepted != CNT_MAX) begin
                    jobs_accepted++;
                end
                res.accepted = 1'b1;
                res.server   = ID_W'(s);
                res.count    = jobs_on_server[s];
                res.total    = jobs_accepted;
                return res;
            end
        end
        // Nobody free: the job is dropped and the total stays as it was.
        return res;
    endfunction

    function automatic t_row row_job(input logic [IDX_W-1:0] idx,
                                     input logic [ARR_W-1:0] arr,
                                     input logic [SVC_W-1:0] svc);
        t_row r;
        r      = '0;
        r.kind = ROW_JOB;
        r.idx  = idx;
        r.arr  = arr;
        r.svc  = svc;
        return r;
    endfunction

    function automatic t_row row_checked(input logic [IDX_W-1:0] idx,
                                         input logic [ARR_W-1:0] arr,
                                         input logic [SVC_W-1:0] svc,
                                         input logic acc,
                                         input logic [ID_W-1:0] srv,
                                         input logic [CNT_W-1:0] cnt,
                                         input logic [CNT_W-1:0] tot);
        t_row r;
        r      = row_job(idx, arr, svc);
        r.kind = ROW_CHECKED;
        r.want = '{acc, srv, cnt, tot};
        return r;
    endfunction

    function automatic t_row row_servers(input logic [CFG_W-1:0] value);
        t_row r;
        r         = '0;
        r.kind    = ROW_SERVERS;
        r.servers = value;
        return r;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Pull valid low and wait until every outstanding result has come back.
    // Each job yields exactly one result, so the block is idle afterwards.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_servers(input logic [CFG_W-1:0] value);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        servers_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one job transaction, idling first at the sender's rate, and hold
    // it until the block takes it. The outcome is predicted at the accepting
    // edge; a typed-in outcome, where given, is what gets compared.
    task automatic offer_job(input logic [IDX_W-1:0] idx,
                             input logic [ARR_W-1:0] arr,
                             input logic [SVC_W-1:0] svc,
                             input logic typed,
                             input t_outcome typed_want);
        t_outcome predicted;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_job_index    <= idx;
        i_arrival_time <= arr;
        i_service_time <= svc;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predicted = dispatch_job(idx, arr, svc);
        pending_outcomes.insert(pending_outcomes.size(), typed ? typed_want : predicted);
    endtask

    // Receiver: random stall at the current rate, or a long hold-off when the
    // stimulus asks for one so that the block fills up and stalls its input.
    always @(negedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Every result transaction is matched against the oldest pending outcome.
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t unexpected result: expected none, actual acc %0d srv %0d cnt %0h tot %0h",
                         $time, o_accepted, o_server_id, o_server_job_count, o_total_accepted);
            end else begin
                want = pending_outcomes.pop_front();
                check_field("accepted", CNT_W'(want.accepted), CNT_W'(o_accepted));
                check_field("server_id", CNT_W'(want.server), CNT_W'(o_server_id));
                check_field("server_job_count", want.count, o_server_job_count);
                check_field("total_accepted", want.total, o_total_accepted);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned      now_tick;
        int               burst_left;
        int               n;
        logic [IDX_W-1:0] idx;
        logic [ARR_W-1:0] arr;
        logic [SVC_W-1:0] svc;
        logic [IDX_W-1:0] job_seq;
        logic [CFG_W-1:0] servers_value;

        foreach (busy_until_tick[s]) begin
            busy_until_tick[s] = '0;
            jobs_on_server[s]  = '0;
        end
        jobs_accepted = '0;
        servers_reg   = CFG_W'(NUM_SERVERS_RST);
        now_tick      = 100;
        burst_left    = 0;
        job_seq       = '0;

        // Directed jobs start from the reset state with all sixteen servers
        // free. Typed-in outcomes cover the cases that are obvious by hand:
        // a job released exactly at its arrival, a busy start server that
        // pushes the job to the next one, a wrap past the top server, an
        // arrival earlier than the one before, drops with a single server,
        // and register values of zero and above the maximum. Server 15 is
        // parked on the largest arrival and service so it stays busy for the
        // rest of the run, which keeps forcing wraps whenever all sixteen
        // servers are in use.
        dir_rows = '{
            row_checked(16'd0, 31'd0, 16'd0, 1'b1, 4'd0, 32'd1, 32'd1),
            row_checked(16'd0, 31'd0, 16'd5, 1'b1, 4'd0, 32'd2, 32'd2),
            row_checked(16'd0, 31'd3, 16'd1, 1'b1, 4'd1, 32'd1, 32'd3),
            row_checked(16'd16, 31'd5, 16'd0, 1'b1, 4'd0, 32'd3, 32'd4),
            row_checked(16'hFFFF, 31'h7FFF_FFFF, 16'hFFFF, 1'b1, 4'd15, 32'd1, 32'd5),
            row_checked(16'd15, 31'd6, 16'd0, 1'b1, 4'd0, 32'd4, 32'd6),
            row_checked(16'd1, 31'd2, 16'd0, 1'b1, 4'd2, 32'd1, 32'd7),
            row_servers(5'd1),
            row_checked(16'hFFFF, 31'd6, 16'd10, 1'b1, 4'd0, 32'd5, 32'd8),
            row_checked(16'd3, 31'd10, 16'd0, 1'b0, 4'd0, 32'd0, 32'd8),
            row_servers(5'd0),
            row_checked(16'd0, 31'd15, 16'd0, 1'b0, 4'd0, 32'd0, 32'd8),
            row_checked(16'h8000, 31'd16, 16'd1, 1'b1, 4'd0, 32'd6, 32'd9),
            row_servers(5'd31),
            row_checked(16'd31, 31'd17, 16'd0, 1'b1, 4'd0, 32'd7, 32'd10),
            row_job(16'h5555, 31'd20, 16'hAAAA),
            row_job(16'hAAAA, 31'd21, 16'h5555),
            row_job(16'h0007, 31'd21, 16'h0100),
            row_job(16'h00F0, 31'd21, 16'h0000),
            row_servers(5'd17),
            row_job(16'h001F, 31'd22, 16'h0040)
        };

        send_idle_pct = 26;
        recv_idle_pct = 65;

        // Synchronous reset held from the start and released on a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_SERVERS) begin
                write_servers(dir_rows[r].servers);
            end else begin
                offer_job(dir_rows[r].idx, dir_rows[r].arr, dir_rows[r].svc,
                          dir_rows[r].kind == ROW_CHECKED, dir_rows[r].want);
            end
        end

        // Random phases, each under its own server count. Most jobs follow a
        // moving clock in bursts of small steps scaled to the server count, so
        // servers keep filling and freeing; between bursts the clock jumps
        // ahead to exercise the upper arrival bits. A small share of jobs
        // arrive earlier than the clock to hit the out-of-order case.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 26;
                recv_idle_pct = 65;
            end else if (ph < 6) begin
                send_idle_pct = 65;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (ph)
                0:       servers_value = 5'd16;
                1:       servers_value = 5'd1;
                2:       servers_value = 5'd0;
                3:       servers_value = 5'd31;
                4:       servers_value = 5'd7;
                5:       servers_value = 5'd17;
                6:       servers_value = CFG_W'($urandom_range(2, 15));
                default: servers_value = 5'd12;
            endcase
            write_servers(servers_value);
            n = active_servers();

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                // The sender stops once mid-run until the block has answered
                // everything, and once the receiver holds off for a long time
                // while jobs keep coming.
                if (ph == 2 && i == ITEMS_PER_PHASE / 2) begin
                    wait_for_results();
                end
                if (ph == 4 && i == 10) begin
                    hold_requests++;
                end

                if ($urandom_range(0, 99) < 8) begin
                    idx = IDX_W'($urandom);
                    arr = ARR_W'($urandom_range(0, now_tick));
                    svc = SVC_W'($urandom);
                end else begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(8, 40);
                        if (now_tick < 32'h6000_0000) begin
                            now_tick += $urandom_range(0, 1 << 26);
                        end
                    end
                    burst_left--;
                    now_tick += $urandom_range(0, 16384 / n);
                    arr = ARR_W'(now_tick);
                    if ($urandom_range(0, 3) == 0) begin
                        svc = SVC_W'($urandom);
                    end else begin
                        svc = SVC_W'($urandom_range(0, 4096));
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        idx = IDX_W'($urandom);
                    end else begin
                        idx = job_seq;
                    end
                    job_seq++;
                end
                offer_job(idx, arr, svc, 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
